[design/msd_pkg.sv]
// Shared codes, widths and types for the motion standby decider.
package msd_pkg;

   // Configuration register indexes and widths
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CFG_TIME_BITS  = 32;
   localparam int THRESH_BITS    = 18;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IDLE_TIMEOUT  = 3'd0,
      CSR_WAKE_GRACE    = 3'd1,
      CSR_LIFT_STABLE   = 3'd2,
      CSR_SET_DOWN_HOLD = 3'd3,
      CSR_STILL_THRESH  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_TIME   = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_ENTER  = 2'd2,
      KIND_WAKE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CTX_PLAYING = 2'd0,
      CTX_PAUSED  = 2'd1,
      CTX_MENU    = 2'd2,
      CTX_OTHER   = 2'd3
   } context_type;

   typedef enum logic [1:0] {
      FLAT_NONE = 2'd0,
      FLAT_UP   = 2'd1,
      FLAT_DOWN = 2'd2,
      FLAT_BAD  = 2'd3
   } flat_type;

   typedef enum logic [1:0] {
      VERDICT_NONE  = 2'd0,
      VERDICT_ENTER = 2'd1,
      VERDICT_WAKE  = 2'd2,
      VERDICT_RSVD  = 2'd3
   } verdict_type;

endpackage

[design/motion_standby_decider.sv]
// Top level of the motion standby decider: input register, decision logic, result register.
//
// Usage: each request beat carries one event (time update, accelerometer sample,
// external standby entry or external wake) with its time stamp, screen context,
// precomputed flat class and three signed acceleration axes. Every request beat
// yields exactly one response beat with the verdict (none, enter standby, wake),
// the screen-off flag, the standby flag and the wake-allowed flag after the event.
// A beat is taken on req_valid high and req_stall low, and likewise on the rsp_ side.
// A request taken into the input register moves through the decision logic into the
// response register as soon as that register is empty or its beat is taken. Throughput:
// one beat per cycle while the receiver does not stall; the decision state is read and
// written in the single stage between the input register and the response register.
// When the receiver stalls, the response register holds; the input register still
// fills once, and req_stall rises only when both registers are occupied.
// Reset (synchronous, active high) empties both registers, clears the thresholds to
// zero and returns the decision state to awake, set-down armed, nothing held.
// Thresholds are written via the csr_ port while no event is in flight; the user, not the block, ensures it.
module motion_standby_decider #(
   parameter int TIME_BITS  = 32,
   parameter int ACCEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [msd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [msd_pkg::CSR_DATA_BITS-1:0]    csr_wr_data,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_kind,
   input  logic [TIME_BITS-1:0]                 req_now_ms,
   input  logic [1:0]                           req_screen_context,
   input  logic [1:0]                           req_flat_class,
   input  logic signed [ACCEL_BITS-1:0]         req_accel_x,
   input  logic signed [ACCEL_BITS-1:0]         req_accel_y,
   input  logic signed [ACCEL_BITS-1:0]         req_accel_z,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_verdict,
   output logic                                 rsp_screen_off,
   output logic                                 rsp_standby_now,
   output logic                                 rsp_wake_allowed
);
   import msd_pkg::*;

   localparam int CMP_BITS   = (TIME_BITS > CFG_TIME_BITS) ? TIME_BITS : CFG_TIME_BITS;
   localparam int DRIFT_BITS = ACCEL_BITS + 2;
   localparam int DCMP_BITS  = (DRIFT_BITS > THRESH_BITS) ? DRIFT_BITS : THRESH_BITS;

   function automatic logic time_reached(input logic [TIME_BITS-1:0] now,
                                         input logic [TIME_BITS-1:0] since,
                                         input logic [CFG_TIME_BITS-1:0] limit);
      logic [TIME_BITS-1:0] diff;
      diff = now - since;
      return CMP_BITS'(diff) >= CMP_BITS'(limit);
   endfunction

   function automatic logic [ACCEL_BITS-1:0] abs_diff(input logic [ACCEL_BITS-1:0] a,
                                                      input logic [ACCEL_BITS-1:0] b);
      logic [ACCEL_BITS:0] d;
      d = {a[ACCEL_BITS-1], a} - {b[ACCEL_BITS-1], b};
      if (d[ACCEL_BITS]) begin
         d = -d;
      end
      return d[ACCEL_BITS-1:0];
   endfunction

   // configuration registers
   logic [CFG_TIME_BITS-1:0] idle_timeout_ff, wake_grace_ff, lift_stable_ff, hold_time_ff;
   logic [THRESH_BITS-1:0]   still_thresh_ff;

   // input register
   logic                   in_valid_ff, in_valid_in;
   kind_type               kind_ff;
   logic [TIME_BITS-1:0]   now_ff;
   logic [1:0]             ctx_ff;
   flat_type               flat_ff;
   logic [ACCEL_BITS-1:0]  ax_ff, ay_ff, az_ff;

   // decision state
   logic                   standby_ff, standby_in;
   logic [TIME_BITS-1:0]   entered_ff, entered_in;
   logic [TIME_BITS-1:0]   activity_ff, activity_in;
   logic                   armed_ff, armed_in;
   logic                   rested_ff, rested_in;
   logic                   lift_pend_ff, lift_pend_in;
   logic                   ctx_seen_ff, ctx_seen_in;
   logic [1:0]             prev_ctx_ff, prev_ctx_in;
   flat_type               hold_face_ff, hold_face_in;
   logic [TIME_BITS-1:0]   hold_start_ff, hold_start_in;
   logic [TIME_BITS-1:0]   lift_start_ff, lift_start_in;
   logic [ACCEL_BITS-1:0]  ref_x_ff, ref_x_in, ref_y_ff, ref_y_in, ref_z_ff, ref_z_in;

   // response register
   logic                   out_valid_ff, out_valid_in;
   verdict_type            verdict_ff, verdict_in;
   logic                   screen_off_ff, screen_off_in;
   logic                   standby_now_ff, standby_now_in;
   logic                   wake_ok_ff, wake_ok_in;

   logic                   advance;
   logic                   req_take;
   flat_type               flat;
   logic                   reading_ctx;
   logic                   idle_ctx;
   logic [DRIFT_BITS-1:0]  drift;
   logic                   drift_big;
   logic                   idle_check;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign flat        = (flat_ff == FLAT_BAD) ? FLAT_NONE : flat_ff;
   assign reading_ctx = (ctx_ff == CTX_PLAYING) || (ctx_ff == CTX_PAUSED);
   assign idle_ctx    = (ctx_ff == CTX_PAUSED) || (ctx_ff == CTX_MENU);
   assign drift       = DRIFT_BITS'(abs_diff(ax_ff, ref_x_ff))
                      + DRIFT_BITS'(abs_diff(ay_ff, ref_y_ff))
                      + DRIFT_BITS'(abs_diff(az_ff, ref_z_ff));
   assign drift_big   = DCMP_BITS'(drift) > DCMP_BITS'(still_thresh_ff);

   always_comb begin
      standby_in    = standby_ff;
      entered_in    = entered_ff;
      activity_in   = activity_ff;
      armed_in      = armed_ff;
      rested_in     = rested_ff;
      lift_pend_in  = lift_pend_ff;
      ctx_seen_in   = ctx_seen_ff;
      prev_ctx_in   = prev_ctx_ff;
      hold_face_in  = hold_face_ff;
      hold_start_in = hold_start_ff;
      lift_start_in = lift_start_ff;
      ref_x_in      = ref_x_ff;
      ref_y_in      = ref_y_ff;
      ref_z_in      = ref_z_ff;
      verdict_in    = VERDICT_NONE;
      screen_off_in = 1'b0;
      idle_check    = 1'b0;

      // time updates and samples restart the idle countdown on a new context
      if ((kind_ff == KIND_TIME || kind_ff == KIND_SAMPLE)
          && (!ctx_seen_ff || ctx_ff != prev_ctx_ff)) begin
         ctx_seen_in = 1'b1;
         prev_ctx_in = ctx_ff;
         activity_in = now_ff;
      end

      unique case (kind_ff)
         KIND_TIME: begin
            idle_check = !standby_ff;
         end
         KIND_SAMPLE: begin
            if (standby_ff) begin
               if (flat != FLAT_NONE) begin
                  rested_in    = 1'b1;
                  lift_pend_in = 1'b0;
               end else if (rested_ff) begin
                  if (!lift_pend_ff) begin
                     lift_pend_in  = 1'b1;
                     lift_start_in = now_ff;
                  end else if (time_reached(now_ff, lift_start_ff, lift_stable_ff)
                               && time_reached(now_ff, entered_ff, wake_grace_ff)) begin
                     standby_in   = 1'b0;
                     activity_in  = now_ff;
                     lift_pend_in = 1'b0;
                     armed_in     = 1'b1;
                     hold_face_in = FLAT_NONE;
                     verdict_in   = VERDICT_WAKE;
                  end
               end
            end else if (flat == FLAT_NONE) begin
               armed_in     = 1'b1;
               hold_face_in = FLAT_NONE;
               idle_check   = 1'b1;
            end else if (!reading_ctx || !armed_ff) begin
               hold_face_in = FLAT_NONE;
               idle_check   = 1'b1;
            end else if (flat != hold_face_ff || drift_big) begin
               // new face or too much motion: restart the hold here
               hold_face_in  = flat;
               hold_start_in = now_ff;
               ref_x_in      = ax_ff;
               ref_y_in      = ay_ff;
               ref_z_in      = az_ff;
               idle_check    = 1'b1;
            end else if (time_reached(now_ff, hold_start_ff, hold_time_ff)) begin
               standby_in    = 1'b1;
               entered_in    = now_ff;
               rested_in     = 1'b1;
               lift_pend_in  = 1'b0;
               hold_face_in  = FLAT_NONE;
               verdict_in    = VERDICT_ENTER;
               screen_off_in = (flat == FLAT_DOWN);
            end else begin
               idle_check = 1'b1;
            end
         end
         KIND_ENTER: begin
            if (!standby_ff) begin
               standby_in   = 1'b1;
               entered_in   = now_ff;
               rested_in    = 1'b0;
               lift_pend_in = 1'b0;
               hold_face_in = FLAT_NONE;
            end
         end
         KIND_WAKE: begin
            if (standby_ff) begin
               standby_in   = 1'b0;
               activity_in  = now_ff;
               armed_in     = 1'b0;
               lift_pend_in = 1'b0;
               hold_face_in = FLAT_NONE;
            end
         end
         default: begin
         end
      endcase

      // idle rule sees the refreshed activity time and the updated hold face
      if (idle_check && idle_timeout_ff != '0 && idle_ctx
          && time_reached(now_ff, activity_in, idle_timeout_ff)) begin
         standby_in   = 1'b1;
         entered_in   = now_ff;
         rested_in    = (hold_face_in != FLAT_NONE);
         lift_pend_in = 1'b0;
         hold_face_in = FLAT_NONE;
         verdict_in   = VERDICT_ENTER;
      end

      standby_now_in = standby_in;
      wake_ok_in     = !standby_in || time_reached(now_ff, entered_in, wake_grace_ff);
   end

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff <= '0;
         wake_grace_ff   <= '0;
         lift_stable_ff  <= '0;
         hold_time_ff    <= '0;
         still_thresh_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IDLE_TIMEOUT:  idle_timeout_ff <= csr_wr_data;
            CSR_WAKE_GRACE:    wake_grace_ff   <= csr_wr_data;
            CSR_LIFT_STABLE:   lift_stable_ff  <= csr_wr_data;
            CSR_SET_DOWN_HOLD: hold_time_ff    <= csr_wr_data;
            CSR_STILL_THRESH:  still_thresh_ff <= csr_wr_data[THRESH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake control and decision state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         standby_ff    <= 1'b0;
         entered_ff    <= '0;
         activity_ff   <= '0;
         armed_ff      <= 1'b1;
         rested_ff     <= 1'b0;
         lift_pend_ff  <= 1'b0;
         ctx_seen_ff   <= 1'b0;
         prev_ctx_ff   <= '0;
         hold_face_ff  <= FLAT_NONE;
         hold_start_ff <= '0;
         lift_start_ff <= '0;
         ref_x_ff      <= '0;
         ref_y_ff      <= '0;
         ref_z_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            standby_ff    <= standby_in;
            entered_ff    <= entered_in;
            activity_ff   <= activity_in;
            armed_ff      <= armed_in;
            rested_ff     <= rested_in;
            lift_pend_ff  <= lift_pend_in;
            ctx_seen_ff   <= ctx_seen_in;
            prev_ctx_ff   <= prev_ctx_in;
            hold_face_ff  <= hold_face_in;
            hold_start_ff <= hold_start_in;
            lift_start_ff <= lift_start_in;
            ref_x_ff      <= ref_x_in;
            ref_y_ff      <= ref_y_in;
            ref_z_ff      <= ref_z_in;
         end
      end
   end

   // payload registers: load the input beat, hold the result until taken
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= kind_type'(req_kind);
         now_ff  <= req_now_ms;
         ctx_ff  <= req_screen_context;
         flat_ff <= flat_type'(req_flat_class);
         ax_ff   <= req_accel_x;
         ay_ff   <= req_accel_y;
         az_ff   <= req_accel_z;
      end
      if (advance) begin
         verdict_ff     <= verdict_in;
         screen_off_ff  <= screen_off_in;
         standby_now_ff <= standby_now_in;
         wake_ok_ff     <= wake_ok_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_screen_off   = screen_off_ff;
   assign rsp_standby_now  = standby_now_ff;
   assign rsp_wake_allowed = wake_ok_ff;

endmodule

[tb/motion_standby_decider_tb.sv]
// Self-checking testbench for the motion standby decider: random and directed events.
`timescale 1ns / 1ps

module motion_standby_decider_tb;
   import msd_pkg::*;

   typedef struct {
      kind_type            kind;
      logic [31:0]         now_ms;
      context_type         ctx;
      flat_type            flat;
      logic signed [15:0]  ax;
      logic signed [15:0]  ay;
      logic signed [15:0]  az;
   } motion_event_type;

   typedef struct packed {
      logic        screen_off;
      verdict_type verdict;
   } outcome_type;

   typedef struct packed {
      verdict_type verdict;
      logic        screen_off;
      logic        standby_now;
      logic        wake_allowed;
   } decision_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0]         csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]          csr_wr_data = '0;

   logic               req_valid          = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind           = '0;
   logic [31:0]        req_now_ms         = '0;
   logic [1:0]         req_screen_context = '0;
   logic [1:0]         req_flat_class     = '0;
   logic signed [15:0] req_accel_x        = '0;
   logic signed [15:0] req_accel_y        = '0;
   logic signed [15:0] req_accel_z        = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_verdict;
   logic        rsp_screen_off;
   logic        rsp_standby_now;
   logic        rsp_wake_allowed;

   motion_standby_decider dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_now_ms         (req_now_ms),
      .req_screen_context (req_screen_context),
      .req_flat_class     (req_flat_class),
      .req_accel_x        (req_accel_x),
      .req_accel_y        (req_accel_y),
      .req_accel_z        (req_accel_z),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_verdict        (rsp_verdict),
      .rsp_screen_off     (rsp_screen_off),
      .rsp_standby_now    (rsp_standby_now),
      .rsp_wake_allowed   (rsp_wake_allowed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Thresholds as last written
   logic [31:0]            cfg_idle  = '0;
   logic [31:0]            cfg_grace = '0;
   logic [31:0]            cfg_lift  = '0;
   logic [31:0]            cfg_hold  = '0;
   logic [THRESH_BITS-1:0] cfg_still = '0;

   // Decision state, starting from its reset values
   logic        standby_flag  = 1'b0;
   logic [31:0] standby_since = '0;
   logic [31:0] activity_ms   = '0;
   logic        setdown_armed = 1'b1;
   logic        flat_rested   = 1'b0;
   logic        lift_waiting  = 1'b0;
   logic        ctx_valid     = 1'b0;
   context_type ctx_last      = CTX_PLAYING;
   flat_type    held_face     = FLAT_NONE;
   logic [31:0] hold_since    = '0;
   logic [31:0] lift_since    = '0;
   int          anchor_x      = 0;
   int          anchor_y      = 0;
   int          anchor_z      = 0;

   motion_event_type queued_events[$];
   decision_type     awaited[$];
   int               failures    = 0;
   int               events_made = 0;
   logic [31:0]      stamp_ms    = '0;
   int unsigned      step_max    = 4;
   int unsigned      jitter_span = 0;

   function automatic logic [31:0] since_ms(logic [31:0] now, logic [31:0] t);
      return now - t;
   endfunction

   function automatic int gap_abs(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic outcome_type enter_standby(logic [31:0] now, logic down);
      outcome_type o;
      standby_flag  = 1'b1;
      standby_since = now;
      flat_rested   = (held_face != FLAT_NONE);
      lift_waiting  = 1'b0;
      held_face     = FLAT_NONE;
      o.verdict     = VERDICT_ENTER;
      o.screen_off  = down;
      return o;
   endfunction

   function automatic outcome_type idle_check(logic [31:0] now, context_type c);
      outcome_type o;
      o = '0;
      if (!standby_flag && cfg_idle != 0 && (c == CTX_PAUSED || c == CTX_MENU) &&
          since_ms(now, activity_ms) >= cfg_idle)
         o = enter_standby(now, 1'b0);
      return o;
   endfunction

   function automatic void note_ctx(logic [31:0] now, context_type c);
      if (!ctx_valid || c != ctx_last) begin
         ctx_valid   = 1'b1;
         ctx_last    = c;
         activity_ms = now;
      end
   endfunction

   function automatic outcome_type take_sample(motion_event_type ev);
      outcome_type o;
      flat_type f;
      int drift;
      o = '0;
      note_ctx(ev.now_ms, ev.ctx);
      f = (ev.flat == FLAT_BAD) ? FLAT_NONE : ev.flat;
      if (standby_flag) begin
         if (f != FLAT_NONE) begin
            flat_rested  = 1'b1;
            lift_waiting = 1'b0;
            return o;
         end
         if (!flat_rested)
            return o;
         if (!lift_waiting) begin
            lift_waiting = 1'b1;
            lift_since   = ev.now_ms;
            return o;
         end
         if (since_ms(ev.now_ms, lift_since) >= cfg_lift &&
             since_ms(ev.now_ms, standby_since) >= cfg_grace) begin
            standby_flag  = 1'b0;
            activity_ms   = ev.now_ms;
            lift_waiting  = 1'b0;
            setdown_armed = 1'b1;
            held_face     = FLAT_NONE;
            o.verdict     = VERDICT_WAKE;
         end
         return o;
      end
      if (f == FLAT_NONE) begin
         setdown_armed = 1'b1;
         held_face     = FLAT_NONE;
         return idle_check(ev.now_ms, ev.ctx);
      end
      if (!(ev.ctx == CTX_PLAYING || ev.ctx == CTX_PAUSED) || !setdown_armed) begin
         held_face = FLAT_NONE;
         return idle_check(ev.now_ms, ev.ctx);
      end
      drift = gap_abs(int'(ev.ax), anchor_x) + gap_abs(int'(ev.ay), anchor_y)
            + gap_abs(int'(ev.az), anchor_z);
      // a new face or too much drift restarts the hold from this sample
      if (f != held_face || drift > int'(cfg_still)) begin
         held_face  = f;
         hold_since = ev.now_ms;
         anchor_x   = int'(ev.ax);
         anchor_y   = int'(ev.ay);
         anchor_z   = int'(ev.az);
         return idle_check(ev.now_ms, ev.ctx);
      end
      if (since_ms(ev.now_ms, hold_since) >= cfg_hold)
         return enter_standby(ev.now_ms, f == FLAT_DOWN);
      return idle_check(ev.now_ms, ev.ctx);
   endfunction

   function automatic decision_type decide(motion_event_type ev);
      decision_type d;
      outcome_type o;
      o = '0;
      case (ev.kind)
         KIND_TIME: begin
            note_ctx(ev.now_ms, ev.ctx);
            o = idle_check(ev.now_ms, ev.ctx);
         end
         KIND_SAMPLE: o = take_sample(ev);
         KIND_ENTER: if (!standby_flag) begin
            standby_flag  = 1'b1;
            standby_since = ev.now_ms;
            flat_rested   = 1'b0;
            lift_waiting  = 1'b0;
            held_face     = FLAT_NONE;
         end
         KIND_WAKE: if (standby_flag) begin
            standby_flag  = 1'b0;
            activity_ms   = ev.now_ms;
            setdown_armed = 1'b0;
            lift_waiting  = 1'b0;
            held_face     = FLAT_NONE;
         end
      endcase
      d.verdict      = o.verdict;
      d.screen_off   = o.screen_off;
      d.standby_now  = standby_flag;
      d.wake_allowed = !standby_flag || since_ms(ev.now_ms, standby_since) >= cfg_grace;
      return d;
   endfunction

   // Sender: bursts of beats separated by random gaps
   motion_event_type current;
   int unsigned      burst_left = 0;
   int unsigned      gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            awaited.push_back(decide(current));
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_events.size() != 0) begin
               current = queued_events.pop_front();
               req_valid          <= 1'b1;
               req_kind           <= current.kind;
               req_now_ms         <= current.now_ms;
               req_screen_context <= current.ctx;
               req_flat_class     <= current.flat;
               req_accel_x        <= current.ax;
               req_accel_y        <= current.ay;
               req_accel_z        <= current.az;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Receiver: compare each beat, then pick the next stall level
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_left = 0;
   decision_type   want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited.size() == 0) begin
            $error("response beat with no event outstanding");
            failures++;
         end else begin
            want = awaited.pop_front();
            check_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
            check_field("screen_off", 32'(want.screen_off), 32'(rsp_screen_off));
            check_field("standby_now", 32'(want.standby_now), 32'(rsp_standby_now));
            check_field("wake_allowed", 32'(want.wake_allowed), 32'(rsp_wake_allowed));
         end
      end
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = (stall_mode == STALL_HOLD) ? $urandom_range(1, 10) : $urandom_range(8, 60);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         STALL_HOLD:  rsp_stall <= 1'b1;
      endcase
   end

   function automatic logic signed [15:0] to_axis(int v);
      if (v > 32767)
         return 16'h7FFF;
      if (v < -32768)
         return 16'h8000;
      return v[15:0];
   endfunction

   function automatic int any_axis();
      case ($urandom_range(0, 7))
         0:       return -32768;
         1:       return 32767;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Small wobble that mostly stays inside the stillness threshold
   function automatic int nudge(int base);
      if ($urandom_range(0, 9) == 0)
         return any_axis();
      return base + int'($urandom_range(0, 2 * jitter_span)) - int'(jitter_span);
   endfunction

   function automatic int unsigned next_step();
      case ($urandom_range(0, 39))
         0:          return $urandom;
         1, 2, 3, 4: return 0;
         default:    return $urandom_range(1, step_max);
      endcase
   endfunction

   function automatic logic [31:0] pick_ms(int unsigned hi);
      case ($urandom_range(0, 15))
         0:       return 0;
         1:       return $urandom;
         default: return $urandom_range(1, hi);
      endcase
   endfunction

   function automatic void push_event(kind_type k, context_type c, flat_type f,
                                      int x, int y, int z, int unsigned step);
      motion_event_type ev;
      stamp_ms  = stamp_ms + step;
      ev.kind   = k;
      ev.now_ms = stamp_ms;
      ev.ctx    = c;
      ev.flat   = f;
      ev.ax     = to_axis(x);
      ev.ay     = to_axis(y);
      ev.az     = to_axis(z);
      queued_events.push_back(ev);
      events_made++;
   endfunction

   task automatic random_episode();
      int pick, bx, by, bz;
      context_type c;
      flat_type f;
      pick = $urandom_range(0, 99);
      f    = $urandom_range(0, 1) ? FLAT_UP : FLAT_DOWN;
      bx   = any_axis();
      by   = any_axis();
      bz   = any_axis();
      if (pick < 40) begin
         // set-down: flat and nearly still, mostly on a reading screen
         c = ($urandom_range(0, 5) == 0) ? context_type'($urandom_range(2, 3))
                                         : context_type'($urandom_range(0, 1));
         repeat ($urandom_range(2, 10))
            push_event(KIND_SAMPLE, c, f, nudge(bx), nudge(by), nudge(bz), next_step());
      end else if (pick < 65) begin
         // lift: rest flat, then tilt away and stay tilted
         c = context_type'($urandom_range(0, 3));
         repeat ($urandom_range(1, 3))
            push_event(KIND_SAMPLE, c, f, nudge(bx), nudge(by), nudge(bz), next_step());
         repeat ($urandom_range(2, 8))
            push_event(KIND_SAMPLE, c,
                       ($urandom_range(0, 7) == 0) ? f :
                       ($urandom_range(0, 4) == 0) ? FLAT_BAD : FLAT_NONE,
                       any_axis(), any_axis(), any_axis(), next_step());
      end else if (pick < 78) begin
         // idle: time passes on a paused or menu screen
         c = $urandom_range(0, 1) ? CTX_PAUSED : CTX_MENU;
         repeat ($urandom_range(2, 6))
            push_event(KIND_TIME, c, flat_type'($urandom_range(0, 3)),
                       any_axis(), any_axis(), any_axis(), 2 * next_step());
      end else if (pick < 88) begin
         push_event($urandom_range(0, 1) ? KIND_ENTER : KIND_WAKE,
                    context_type'($urandom_range(0, 3)), flat_type'($urandom_range(0, 3)),
                    any_axis(), any_axis(), any_axis(), next_step());
      end else begin
         push_event(kind_type'($urandom_range(0, 3)), context_type'($urandom_range(0, 3)),
                    flat_type'($urandom_range(0, 3)), any_axis(), any_axis(), any_axis(),
                    next_step());
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_IDLE_TIMEOUT:  cfg_idle  = val;
         CSR_WAKE_GRACE:    cfg_grace = val;
         CSR_LIFT_STABLE:   cfg_lift  = val;
         CSR_SET_DOWN_HOLD: cfg_hold  = val;
         CSR_STILL_THRESH:  cfg_still = val[THRESH_BITS-1:0];
      endcase
   endtask

   task automatic load_config(input logic [31:0] idle, grace, lift, hold, still);
      write_reg(CSR_IDLE_TIMEOUT, idle);
      write_reg(CSR_WAKE_GRACE, grace);
      write_reg(CSR_LIFT_STABLE, lift);
      write_reg(CSR_SET_DOWN_HOLD, hold);
      write_reg(CSR_STILL_THRESH, still);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      jitter_span = 32'(cfg_still) / 3;
   endtask

   // Drain: nothing queued, nothing on the wire, nothing outstanding
   task automatic wait_idle();
      do
         @(negedge clock);
      while (queued_events.size() != 0 || req_valid || awaited.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   initial begin
      int target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      load_config(20, 3, 0, 5, 196605);
      push_event(KIND_TIME,   CTX_PLAYING, FLAT_NONE, 0, 0, 0, 0);
      push_event(KIND_SAMPLE, CTX_PLAYING, FLAT_BAD, 0, 0, 0, 1);
      push_event(KIND_SAMPLE, CTX_PLAYING, FLAT_UP, -32768, -32768, -32768, 1);
      // full-scale swing on all axes: largest drift, equal to the threshold and so not above it
      push_event(KIND_SAMPLE, CTX_PLAYING, FLAT_UP, 32767, 32767, 32767, 2);
      push_event(KIND_SAMPLE, CTX_PLAYING, FLAT_UP, 32767, 32767, 32767, 3);
      push_event(KIND_TIME,   CTX_MENU, FLAT_NONE, 0, 0, 0, 1);
      push_event(KIND_SAMPLE, CTX_MENU, FLAT_NONE, 100, -100, 4096, 1);
      push_event(KIND_SAMPLE, CTX_MENU, FLAT_NONE, 100, -100, 4096, 0);
      push_event(KIND_SAMPLE, CTX_MENU, FLAT_NONE, 100, -100, 4096, 1);
      push_event(KIND_WAKE,   CTX_OTHER, FLAT_DOWN, 1, 2, 3, 1);
      push_event(KIND_ENTER,  CTX_PAUSED, FLAT_UP, -1, -2, -3, 1);
      push_event(KIND_ENTER,  CTX_PLAYING, FLAT_NONE, 0, 0, 0, 1);
      push_event(KIND_SAMPLE, CTX_OTHER, FLAT_NONE, 0, 0, 0, 1);
      push_event(KIND_SAMPLE, CTX_OTHER, FLAT_DOWN, 0, 0, -4096, 1);
      push_event(KIND_WAKE,   CTX_PLAYING, FLAT_NONE, 0, 0, 0, 1);
      push_event(KIND_SAMPLE, CTX_PLAYING, FLAT_DOWN, 0, 0, -4096, 1);
      push_event(KIND_SAMPLE, CTX_MENU, FLAT_UP, 0, 0, 4096, 1);
      push_event(KIND_SAMPLE, CTX_PLAYING, FLAT_NONE, 4096, 0, 0, 1);
      push_event(KIND_SAMPLE, CTX_PAUSED, FLAT_DOWN, 0, 0, -4096, 1);
      // time stamp wraps past zero during the hold
      push_event(KIND_SAMPLE, CTX_PAUSED, FLAT_DOWN, 0, 0, -4096, 32'hFFFF_FFF0);
      push_event(KIND_WAKE,   CTX_PAUSED, FLAT_NONE, 0, 0, 0, 1);
      push_event(KIND_TIME,   CTX_PAUSED, FLAT_NONE, 0, 0, 0, 10);
      push_event(KIND_TIME,   CTX_PAUSED, FLAT_NONE, 0, 0, 0, 10);
      push_event(KIND_TIME,   CTX_OTHER, FLAT_NONE, 0, 0, 0, 1);

      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               load_config(0, 0, 0, 0, 0);
               step_max = 3;
            end
            1: begin
               load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 196605);
               step_max = 1000;
            end
            default: begin
               load_config(pick_ms(400), pick_ms(120), pick_ms(120), pick_ms(250),
                           ($urandom_range(0, 5) == 0) ? 196605 :
                           ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 3000));
               step_max = $urandom_range(5, 80);
            end
         endcase
         // cross the time stamp wrap in some phases
         if (phase == 3 || phase == 6)
            stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
         target = events_made + 216;
         while (events_made < target)
            random_episode();
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
